// ----- hw/rtl/tgs_pkg.sv -----
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the tripod gait sequencer
// Beat structs, mode and window codes, register indexes and gait tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tgs_pkg;

  // angle resolution, full circle is 2**ANGLE_BITS
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_SPEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_SPEED  = 2'd2;

  // register reset values
  localparam logic [13:0] LANDING_ANGLE_RST = 14'd3640;
  localparam logic [14:0] AIR_SPEED_RST     = 15'd1792;
  localparam logic [14:0] GROUND_SPEED_RST  = 15'd224;

  // gait phases
  localparam logic [1:0] PHASE_START = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  localparam int unsigned NUM_LEGS = 6;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_ROT_L = 2'd1,
    MODE_ROT_R = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  // leg stop windows
  typedef enum logic [2:0] {
    WIN_A = 3'd0,  // a > half
    WIN_B = 3'd1,  // L < a < full - 2L
    WIN_C = 3'd2,  // a > full - L
    WIN_D = 3'd3,  // L < a < 2L
    WIN_E = 3'd4,  // a < L
    WIN_F = 3'd5,  // 2L < a < full - L
    WIN_G = 3'd6   // a > full - 2L
  } win_e;

  // drive speed selection
  typedef enum logic [1:0] {
    SPD_PAIR = 2'd0,
    SPD_NAIR = 2'd1,
    SPD_PGND = 2'd2,
    SPD_NGND = 2'd3
  } spd_e;

  // window per [mode][phase][leg]
  localparam win_e WIN_TAB [3][3][6] = '{
    '{ '{WIN_A, WIN_A, WIN_A, WIN_B, WIN_B, WIN_B},
       '{WIN_C, WIN_C, WIN_C, WIN_D, WIN_D, WIN_D},
       '{WIN_D, WIN_D, WIN_D, WIN_C, WIN_C, WIN_C} },
    '{ '{WIN_A, WIN_A, WIN_A, WIN_B, WIN_B, WIN_B},
       '{WIN_C, WIN_E, WIN_C, WIN_F, WIN_D, WIN_F},
       '{WIN_D, WIN_F, WIN_D, WIN_E, WIN_C, WIN_E} },
    '{ '{WIN_A, WIN_A, WIN_A, WIN_G, WIN_E, WIN_G},
       '{WIN_E, WIN_C, WIN_E, WIN_D, WIN_F, WIN_D},
       '{WIN_F, WIN_D, WIN_F, WIN_C, WIN_E, WIN_C} }
  };

  // speed per [mode][phase][leg]
  localparam spd_e SPD_TAB [3][3][6] = '{
    '{ '{SPD_PAIR, SPD_PAIR, SPD_PAIR, SPD_PAIR, SPD_PAIR, SPD_PAIR},
       '{SPD_PAIR, SPD_PAIR, SPD_PAIR, SPD_PGND, SPD_PGND, SPD_PGND},
       '{SPD_PGND, SPD_PGND, SPD_PGND, SPD_PAIR, SPD_PAIR, SPD_PAIR} },
    '{ '{SPD_PAIR, SPD_NAIR, SPD_PAIR, SPD_NAIR, SPD_PAIR, SPD_NAIR},
       '{SPD_PAIR, SPD_NAIR, SPD_PAIR, SPD_NGND, SPD_PGND, SPD_NGND},
       '{SPD_PGND, SPD_NGND, SPD_PGND, SPD_NAIR, SPD_PAIR, SPD_NAIR} },
    '{ '{SPD_NAIR, SPD_PAIR, SPD_NAIR, SPD_PAIR, SPD_NAIR, SPD_PAIR},
       '{SPD_NAIR, SPD_PAIR, SPD_NAIR, SPD_PGND, SPD_NGND, SPD_PGND},
       '{SPD_NGND, SPD_PGND, SPD_NGND, SPD_PAIR, SPD_NAIR, SPD_PAIR} }
  };

  // input beat
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] angle_leg0;
    logic [15:0] angle_leg1;
    logic [15:0] angle_leg2;
    logic [15:0] angle_leg3;
    logic [15:0] angle_leg4;
    logic [15:0] angle_leg5;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic signed [15:0] velocity_leg0;
    logic signed [15:0] velocity_leg1;
    logic signed [15:0] velocity_leg2;
    logic signed [15:0] velocity_leg3;
    logic signed [15:0] velocity_leg4;
    logic signed [15:0] velocity_leg5;
    logic [1:0]         gait_phase_out;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tripod_gait_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// tripod_gait_sequencer_unit: alternating tripod gait sequencer
// Turns a motion mode and six leg angles into six leg velocity commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one control
//   tick: motion mode and six binary leg angles. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries six velocity commands
//   and the gait phase after the tick.
//   The result of a taken beat is registered and shown in the next cycle.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   gait state is updated in the same cycle the beat is taken, so the next
//   tick can follow at once.
//   A single result register parts the two channels. While it holds a beat
//   and the receiver stalls, in_stall_o is raised; a new beat is taken in
//   the same cycle the waiting result leaves.
//   Reset empties the result register, sets the phase to start, clears the
//   leg done flags, sets the last mode to stop and loads the register
//   defaults. Configuration writes (cfg_we_i) take effect at once; the user
//   must make them only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module tripod_gait_sequencer_unit #(
  parameter int unsigned ANGLE_BITS = tgs_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire tgs_pkg::in_item_t              in_data_i,
  // output channel
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      tgs_pkg::out_item_t             out_data_o,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [tgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tgs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // compare width: holds the full circle and 2L with a sign bit
  localparam int unsigned CW  = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
  // angle bits that are actually used
  localparam int unsigned ABW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam logic signed [CW-1:0] FULL_C = CW'(64'd1 << ANGLE_BITS);
  localparam logic signed [CW-1:0] HALF_C = CW'(64'd1 << (ANGLE_BITS - 1));

  // configuration registers
  logic [13:0] landing_q;
  logic [14:0] air_q;
  logic [14:0] ground_q;

  // gait state
  logic [1:0]                   phase_q, phase_d;
  logic [tgs_pkg::NUM_LEGS-1:0] done_q, done_d;
  logic [1:0]                   last_mode_q;

  // result register
  logic               out_valid_q;
  tgs_pkg::out_item_t out_data_q, out_data_d;

  logic in_acc;

  // window bounds
  logic signed [CW-1:0] l_s, l2_s, fl_s, f2l_s;

  logic [1:0]                   mode_idx;
  logic                         mode_chg;
  logic [1:0]                   ph;
  logic [tgs_pkg::NUM_LEGS-1:0] done_base, hit, done_hit;
  logic [15:0]                  angle [tgs_pkg::NUM_LEGS];
  logic signed [15:0]           vel   [tgs_pkg::NUM_LEGS];
  logic signed [15:0]           air_pos, air_neg, gnd_pos, gnd_neg;

  function automatic logic in_window(
    tgs_pkg::win_e        w,
    logic signed [CW-1:0] a,
    logic signed [CW-1:0] l,
    logic signed [CW-1:0] l2,
    logic signed [CW-1:0] fl,
    logic signed [CW-1:0] f2l
  );
    logic r;
    unique case (w)
      tgs_pkg::WIN_A: r = a > HALF_C;
      tgs_pkg::WIN_B: r = (a > l) && (a < f2l);
      tgs_pkg::WIN_C: r = a > fl;
      tgs_pkg::WIN_D: r = (a > l) && (a < l2);
      tgs_pkg::WIN_E: r = a < l;
      tgs_pkg::WIN_F: r = (a > l2) && (a < fl);
      tgs_pkg::WIN_G: r = a > f2l;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  // handshake: stall only while a finished result is held back
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // window bounds from the landing angle, signed and unwrapped
  always_comb begin
    l_s   = signed'(CW'(landing_q));
    l2_s  = signed'(CW'({landing_q, 1'b0}));
    fl_s  = FULL_C - l_s;
    f2l_s = FULL_C - l2_s;
  end

  // speed choices
  always_comb begin
    air_pos = signed'({1'b0, air_q});
    air_neg = -air_pos;
    gnd_pos = signed'({1'b0, ground_q});
    gnd_neg = -gnd_pos;
  end

  // mode change clears phase and flags before the tick is evaluated
  always_comb begin
    mode_chg  = in_data_i.op != last_mode_q;
    ph        = mode_chg ? tgs_pkg::PHASE_START : phase_q;
    if (ph > tgs_pkg::PHASE_TWO) begin
      ph = tgs_pkg::PHASE_START;
    end
    done_base = mode_chg ? '0 : done_q;
    mode_idx  = (in_data_i.op == tgs_pkg::MODE_STOP) ? tgs_pkg::MODE_FWD : in_data_i.op;
  end

  assign angle[0] = in_data_i.angle_leg0;
  assign angle[1] = in_data_i.angle_leg1;
  assign angle[2] = in_data_i.angle_leg2;
  assign angle[3] = in_data_i.angle_leg3;
  assign angle[4] = in_data_i.angle_leg4;
  assign angle[5] = in_data_i.angle_leg5;

  // per leg window test and velocity
  for (genvar g = 0; g < tgs_pkg::NUM_LEGS; g++) begin : g_leg
    logic signed [CW-1:0] a_s;
    tgs_pkg::win_e        w;
    tgs_pkg::spd_e        s;
    assign a_s = signed'(CW'(angle[g][ABW-1:0]));
    assign w   = tgs_pkg::WIN_TAB[mode_idx][ph][g];
    assign s   = tgs_pkg::SPD_TAB[mode_idx][ph][g];
    always_comb begin
      hit[g] = (in_data_i.op != tgs_pkg::MODE_STOP) &&
               in_window(w, a_s, l_s, l2_s, fl_s, f2l_s);
      if (in_data_i.op == tgs_pkg::MODE_STOP || hit[g]) begin
        vel[g] = '0;
      end else begin
        unique case (s)
          tgs_pkg::SPD_PAIR: vel[g] = air_pos;
          tgs_pkg::SPD_NAIR: vel[g] = air_neg;
          tgs_pkg::SPD_PGND: vel[g] = gnd_pos;
          tgs_pkg::SPD_NGND: vel[g] = gnd_neg;
          default:           vel[g] = '0;
        endcase
      end
    end
  end

  // phase update
  always_comb begin
    done_hit = done_base | hit;
    phase_d  = ph;
    done_d   = done_hit;
    if (in_data_i.op != tgs_pkg::MODE_STOP) begin
      if (ph == tgs_pkg::PHASE_START) begin
        if (done_hit[2:0] == 3'b111) begin
          done_d  = '0;
          phase_d = tgs_pkg::PHASE_ONE;
        end
      end else if (&done_hit) begin
        done_d  = '0;
        phase_d = (ph == tgs_pkg::PHASE_ONE) ? tgs_pkg::PHASE_TWO : tgs_pkg::PHASE_ONE;
      end
    end
  end

  // result beat
  always_comb begin
    out_data_d.velocity_leg0  = vel[0];
    out_data_d.velocity_leg1  = vel[1];
    out_data_d.velocity_leg2  = vel[2];
    out_data_d.velocity_leg3  = vel[3];
    out_data_d.velocity_leg4  = vel[4];
    out_data_d.velocity_leg5  = vel[5];
    out_data_d.gait_phase_out = phase_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      landing_q <= tgs_pkg::LANDING_ANGLE_RST;
      air_q     <= tgs_pkg::AIR_SPEED_RST;
      ground_q  <= tgs_pkg::GROUND_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgs_pkg::CFG_LANDING_ANGLE: landing_q <= cfg_data_i[13:0];
        tgs_pkg::CFG_AIR_SPEED:     air_q     <= cfg_data_i;
        tgs_pkg::CFG_GROUND_SPEED:  ground_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gait state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tgs_pkg::PHASE_START;
      done_q      <= '0;
      last_mode_q <= tgs_pkg::MODE_STOP;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        done_q      <= done_d;
        last_mode_q <= in_data_i.op;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tgs_checker.sv -----
// ----------------------------------------------------------------------------
// tgs_checker: port level checks of the tripod gait sequencer
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tgs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire tgs_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire tgs_pkg::out_item_t out_data_o
);

  // a held result stays put while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  else $error("stalled result beat changed");

  // input stalls only while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stalled with no result waiting");

  // every beat taken shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
  else $error("accepted beat produced no result");

  // stop mode drives every leg at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.op == tgs_pkg::MODE_STOP |=>
      out_data_o.velocity_leg0 == '0 && out_data_o.velocity_leg1 == '0 &&
      out_data_o.velocity_leg2 == '0 && out_data_o.velocity_leg3 == '0 &&
      out_data_o.velocity_leg4 == '0 && out_data_o.velocity_leg5 == '0)
  else $error("stop mode beat with non-zero velocity");

  // phase three never appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gait_phase_out != 2'd3)
  else $error("invalid gait phase on output");

endmodule

bind tripod_gait_sequencer_unit tgs_checker u_tgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- test/tb_tripod_gait_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tripod_gait_sequencer_unit: self-checking bench for the tripod gait unit
// Drives mode and leg angle beats with random gaps and receiver stalls, keeps
// its own model of the gait phase and leg done flags, and compares every
// velocity and phase field of each result beat in order of arrival.
// ----------------------------------------------------------------------------

module tb_tripod_gait_sequencer_unit;

  localparam int FULL           = 1 << tgs_pkg::ANGLE_BITS_DEF;
  localparam int HALF           = FULL / 2;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [tgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // stop window per [mode][phase][leg]
  localparam tgs_pkg::win_e GAIT_WIN [3][3][6] = '{
    '{ '{tgs_pkg::WIN_A, tgs_pkg::WIN_A, tgs_pkg::WIN_A,
         tgs_pkg::WIN_B, tgs_pkg::WIN_B, tgs_pkg::WIN_B},
       '{tgs_pkg::WIN_C, tgs_pkg::WIN_C, tgs_pkg::WIN_C,
         tgs_pkg::WIN_D, tgs_pkg::WIN_D, tgs_pkg::WIN_D},
       '{tgs_pkg::WIN_D, tgs_pkg::WIN_D, tgs_pkg::WIN_D,
         tgs_pkg::WIN_C, tgs_pkg::WIN_C, tgs_pkg::WIN_C} },
    '{ '{tgs_pkg::WIN_A, tgs_pkg::WIN_A, tgs_pkg::WIN_A,
         tgs_pkg::WIN_B, tgs_pkg::WIN_B, tgs_pkg::WIN_B},
       '{tgs_pkg::WIN_C, tgs_pkg::WIN_E, tgs_pkg::WIN_C,
         tgs_pkg::WIN_F, tgs_pkg::WIN_D, tgs_pkg::WIN_F},
       '{tgs_pkg::WIN_D, tgs_pkg::WIN_F, tgs_pkg::WIN_D,
         tgs_pkg::WIN_E, tgs_pkg::WIN_C, tgs_pkg::WIN_E} },
    '{ '{tgs_pkg::WIN_A, tgs_pkg::WIN_A, tgs_pkg::WIN_A,
         tgs_pkg::WIN_G, tgs_pkg::WIN_E, tgs_pkg::WIN_G},
       '{tgs_pkg::WIN_E, tgs_pkg::WIN_C, tgs_pkg::WIN_E,
         tgs_pkg::WIN_D, tgs_pkg::WIN_F, tgs_pkg::WIN_D},
       '{tgs_pkg::WIN_F, tgs_pkg::WIN_D, tgs_pkg::WIN_F,
         tgs_pkg::WIN_C, tgs_pkg::WIN_E, tgs_pkg::WIN_C} }
  };

  // drive speed per [mode][phase][leg] when outside the window
  localparam tgs_pkg::spd_e GAIT_DRIVE [3][3][6] = '{
    '{ '{tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR,
         tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR},
       '{tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR,
         tgs_pkg::SPD_PGND, tgs_pkg::SPD_PGND, tgs_pkg::SPD_PGND},
       '{tgs_pkg::SPD_PGND, tgs_pkg::SPD_PGND, tgs_pkg::SPD_PGND,
         tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_PAIR} },
    '{ '{tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR,
         tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR},
       '{tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR,
         tgs_pkg::SPD_NGND, tgs_pkg::SPD_PGND, tgs_pkg::SPD_NGND},
       '{tgs_pkg::SPD_PGND, tgs_pkg::SPD_NGND, tgs_pkg::SPD_PGND,
         tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR} },
    '{ '{tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR,
         tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR},
       '{tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR,
         tgs_pkg::SPD_PGND, tgs_pkg::SPD_NGND, tgs_pkg::SPD_PGND},
       '{tgs_pkg::SPD_NGND, tgs_pkg::SPD_PGND, tgs_pkg::SPD_NGND,
         tgs_pkg::SPD_PAIR, tgs_pkg::SPD_NAIR, tgs_pkg::SPD_PAIR} }
  };

  // gait model and queue of expected velocity beats
  class gait_scoreboard;
    logic [13:0]        landing;
    logic [14:0]        air_spd;
    logic [14:0]        gnd_spd;
    logic [1:0]         phase;
    logic [5:0]         done;
    tgs_pkg::mode_e     last_mode;
    tgs_pkg::out_item_t pending [$];
    int                 errors;

    function new();
      landing   = tgs_pkg::LANDING_ANGLE_RST;
      air_spd   = tgs_pkg::AIR_SPEED_RST;
      gnd_spd   = tgs_pkg::GROUND_SPEED_RST;
      phase     = tgs_pkg::PHASE_START;
      done      = '0;
      last_mode = tgs_pkg::MODE_STOP;
      errors    = 0;
    endfunction

    function void set_reg(logic [tgs_pkg::CFG_IDX_W-1:0] idx,
                          logic [tgs_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        tgs_pkg::CFG_LANDING_ANGLE: landing = val[13:0];
        tgs_pkg::CFG_AIR_SPEED:     air_spd = val;
        tgs_pkg::CFG_GROUND_SPEED:  gnd_spd = val;
        default: ;
      endcase
    endfunction

    // bounds are plain signed ints, so a bound past either end never wraps
    function bit in_window(tgs_pkg::win_e w, int a);
      int lnd;
      lnd = int'(landing);
      case (w)
        tgs_pkg::WIN_A: return a > HALF;
        tgs_pkg::WIN_B: return a > lnd && a < FULL - 2 * lnd;
        tgs_pkg::WIN_C: return a > FULL - lnd;
        tgs_pkg::WIN_D: return a > lnd && a < 2 * lnd;
        tgs_pkg::WIN_E: return a < lnd;
        tgs_pkg::WIN_F: return a > 2 * lnd && a < FULL - lnd;
        default:        return a > FULL - 2 * lnd;
      endcase
    endfunction

    function logic signed [15:0] drive_speed(tgs_pkg::spd_e s);
      case (s)
        tgs_pkg::SPD_PAIR: return {1'b0, air_spd};
        tgs_pkg::SPD_NAIR: return -{1'b0, air_spd};
        tgs_pkg::SPD_PGND: return {1'b0, gnd_spd};
        default:           return -{1'b0, gnd_spd};
      endcase
    endfunction

    // one control tick: update the gait state and queue the expected beat
    function void note_beat(tgs_pkg::in_item_t x);
      tgs_pkg::mode_e     m;
      logic [15:0]        ang [6];
      logic signed [15:0] vel [6];
      tgs_pkg::out_item_t e;
      int                 i;
      m = tgs_pkg::mode_e'(x.op);
      ang[0] = x.angle_leg0;
      ang[1] = x.angle_leg1;
      ang[2] = x.angle_leg2;
      ang[3] = x.angle_leg3;
      ang[4] = x.angle_leg4;
      ang[5] = x.angle_leg5;
      // a new mode restarts the gait, stop included
      if (m != last_mode) begin
        phase     = tgs_pkg::PHASE_START;
        done      = '0;
        last_mode = m;
      end
      for (i = 0; i < tgs_pkg::NUM_LEGS; i++) vel[i] = '0;
      if (m != tgs_pkg::MODE_STOP) begin
        for (i = 0; i < tgs_pkg::NUM_LEGS; i++) begin
          if (in_window(GAIT_WIN[m][phase][i], int'(ang[i]))) begin
            done[i] = 1'b1;
          end else begin
            vel[i] = drive_speed(GAIT_DRIVE[m][phase][i]);
          end
        end
        // start phase waits for the first tripod, then phases alternate
        if (phase == tgs_pkg::PHASE_START) begin
          if (done[2:0] == 3'b111) begin
            done  = '0;
            phase = tgs_pkg::PHASE_ONE;
          end
        end else if (&done) begin
          done  = '0;
          phase = (phase == tgs_pkg::PHASE_ONE) ? tgs_pkg::PHASE_TWO : tgs_pkg::PHASE_ONE;
        end
      end
      e.velocity_leg0  = vel[0];
      e.velocity_leg1  = vel[1];
      e.velocity_leg2  = vel[2];
      e.velocity_leg3  = vel[3];
      e.velocity_leg4  = vel[4];
      e.velocity_leg5  = vel[5];
      e.gait_phase_out = phase;
      pending.push_back(e);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch on %s: expected %0d, got %0d",
                   $realtime, name, $signed(want), $signed(got));
      end
    endfunction

    function void check_beat(tgs_pkg::out_item_t got);
      tgs_pkg::out_item_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result beat with nothing pending: %h", $realtime, got);
        return;
      end
      e = pending.pop_front();
      cmp_field("velocity_leg0", e.velocity_leg0, got.velocity_leg0);
      cmp_field("velocity_leg1", e.velocity_leg1, got.velocity_leg1);
      cmp_field("velocity_leg2", e.velocity_leg2, got.velocity_leg2);
      cmp_field("velocity_leg3", e.velocity_leg3, got.velocity_leg3);
      cmp_field("velocity_leg4", e.velocity_leg4, got.velocity_leg4);
      cmp_field("velocity_leg5", e.velocity_leg5, got.velocity_leg5);
      cmp_field("gait_phase_out", {14'd0, e.gait_phase_out}, {14'd0, got.gait_phase_out});
    endfunction
  endclass

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tgs_pkg::in_item_t              in_data  = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tgs_pkg::out_item_t             out_data;
  logic                           cfg_we   = 1'b0;
  logic [tgs_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [tgs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gait_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  tripod_gait_sequencer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // idle length: mostly short, now and then a long one
  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tgs_pkg::in_item_t pack_tick(logic [1:0] op, int a0, int a1, int a2,
                                                  int a3, int a4, int a5);
    tgs_pkg::in_item_t x;
    x.op         = op;
    x.angle_leg0 = a0[15:0];
    x.angle_leg1 = a1[15:0];
    x.angle_leg2 = a2[15:0];
    x.angle_leg3 = a3[15:0];
    x.angle_leg4 = a4[15:0];
    x.angle_leg5 = a5[15:0];
    return x;
  endfunction

  // angle near a window bound or anywhere; if asked, tries for one inside the window
  function automatic int pick_angle(tgs_pkg::win_e w, bit want_in);
    int lnd;
    int cand;
    int bnd [7];
    int t;
    lnd  = int'(sb.landing);
    bnd  = '{0, lnd, 2 * lnd, FULL - lnd, FULL - 2 * lnd, HALF, FULL - 1};
    cand = 0;
    for (t = 0; t < 24; t++) begin
      if ($urandom_range(0, 2) == 0) begin
        cand = bnd[$urandom_range(0, 6)] + int'($urandom_range(0, 2)) - 1;
        if (cand < 0) cand = 0;
        if (cand > FULL - 1) cand = FULL - 1;
      end else begin
        cand = int'($urandom_range(0, FULL - 1));
      end
      if (!want_in || sb.in_window(w, cand)) return cand;
    end
    return cand;
  endfunction

  // tick that tends to move the gait on from where the model says it is
  function automatic tgs_pkg::in_item_t make_tick(tgs_pkg::mode_e m);
    int          a [6];
    logic [1:0]  ph;
    int          i;
    ph = (m != sb.last_mode) ? tgs_pkg::PHASE_START : sb.phase;
    for (i = 0; i < tgs_pkg::NUM_LEGS; i++) begin
      if (m == tgs_pkg::MODE_STOP) a[i] = int'($urandom_range(0, FULL - 1));
      else a[i] = pick_angle(GAIT_WIN[m][ph][i], $urandom_range(0, 99) < 55);
    end
    return pack_tick(m, a[0], a[1], a[2], a[3], a[4], a[5]);
  endfunction

  // offer one beat, after an optional gap, and hold it until taken
  task automatic send_beat(tgs_pkg::in_item_t x);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? burst_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(x);
  endtask

  // stop offering and let every expected beat come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [13:0] lnd, logic [14:0] air, logic [14:0] gnd);
    logic [tgs_pkg::CFG_DATA_W-1:0] junk;
    junk = tgs_pkg::CFG_DATA_W'($urandom_range(0, 32767));
    cfg_we   <= 1'b1;
    cfg_idx  <= tgs_pkg::CFG_LANDING_ANGLE;
    cfg_data <= {junk[14], lnd};
    sb.set_reg(tgs_pkg::CFG_LANDING_ANGLE, {junk[14], lnd});
    @(posedge clk);
    cfg_idx  <= tgs_pkg::CFG_AIR_SPEED;
    cfg_data <= air;
    sb.set_reg(tgs_pkg::CFG_AIR_SPEED, air);
    @(posedge clk);
    cfg_idx  <= tgs_pkg::CFG_GROUND_SPEED;
    cfg_data <= gnd;
    sb.set_reg(tgs_pkg::CFG_GROUND_SPEED, gnd);
    @(posedge clk);
    // an index with no register behind it must leave everything alone
    cfg_idx  <= CFG_UNUSED_IDX;
    cfg_data <= junk;
    sb.set_reg(CFG_UNUSED_IDX, junk);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // runs of one mode with random angles, broken up by stray ticks
  task automatic run_random(int n);
    int             sent;
    int             run;
    tgs_pkg::mode_e m;
    sent = 0;
    while (sent < n) begin
      m   = tgs_pkg::mode_e'($urandom_range(0, 3));
      run = $urandom_range(3, 25);
      while (run > 0 && sent < n) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(pack_tick(2'($urandom_range(0, 3)),
                              int'($urandom_range(0, FULL - 1)),
                              int'($urandom_range(0, FULL - 1)),
                              int'($urandom_range(0, FULL - 1)),
                              int'($urandom_range(0, FULL - 1)),
                              int'($urandom_range(0, FULL - 1)),
                              int'($urandom_range(0, FULL - 1))));
        else
          send_beat(make_tick(m));
        sent++;
        run--;
      end
    end
  endtask

  task automatic run_phase(logic [13:0] lnd, logic [14:0] air, logic [14:0] gnd, bit squeeze);
    wait_idle();
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    program_regs(lnd, air, gnd);
    if (squeeze) begin
      tx_idle_on = 1'b0;
      holds_asked++;
    end
    run_random(62);
  endtask

  // receiver: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = burst_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check and watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_beat(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin : main_seq
    int lr;
    int k;
    sb = new();
    lr = int'(tgs_pkg::LANDING_ANGLE_RST);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks with the default registers
    send_beat(pack_tick(tgs_pkg::MODE_STOP, 0, 0, 0, 0, 0, 0));
    send_beat(pack_tick(tgs_pkg::MODE_STOP, FULL - 1, FULL - 1, FULL - 1,
                        FULL - 1, FULL - 1, FULL - 1));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, 0, 0, 0, 0, 0, 0));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, HALF, HALF, HALF, HALF, HALF, HALF));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, HALF + 1, HALF + 1, HALF + 1, 0, 0, 0));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, FULL - lr, FULL - lr, FULL - lr, lr, lr, lr));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, FULL - lr + 1, FULL - lr + 1, FULL - lr + 1,
                        lr + 1, lr + 1, lr + 1));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, 2 * lr - 1, 2 * lr - 1, 2 * lr - 1,
                        FULL - 1, FULL - 1, FULL - 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_L, FULL - 1, FULL - 1, FULL - 1,
                        FULL - 1, FULL - 1, FULL - 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_L, FULL - 1, 0, FULL - 1,
                        2 * lr + 1, lr + 1, 2 * lr + 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_L, lr + 1, 2 * lr + 1, lr + 1,
                        lr - 1, FULL - 1, lr - 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_R, FULL - 1, FULL - 1, FULL - 1,
                        FULL - 2 * lr + 1, 0, FULL - 2 * lr + 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_R, lr - 1, FULL - 1, lr - 1,
                        lr + 1, 2 * lr + 1, lr + 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_R, 2 * lr + 1, lr + 1, 2 * lr + 1,
                        FULL - 1, 0, FULL - 1));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_R, 0, 0, 0, 0, 0, 0));
    // switching into stop mid-gait clears the gait
    send_beat(pack_tick(tgs_pkg::MODE_STOP, FULL - 1, FULL - 1, FULL - 1,
                        FULL - 1, FULL - 1, FULL - 1));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, 2 * lr, 2 * lr, 2 * lr, 2 * lr, 2 * lr, 2 * lr));
    send_beat(pack_tick(tgs_pkg::MODE_FWD, FULL - 2 * lr, FULL - 2 * lr, FULL - 2 * lr,
                        FULL - 2 * lr, FULL - 2 * lr, FULL - 2 * lr));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_L, lr, lr, lr, lr, lr, lr));
    send_beat(pack_tick(tgs_pkg::MODE_ROT_R, FULL - 2 * lr, FULL - 2 * lr, FULL - 2 * lr,
                        FULL - 2 * lr, FULL - 2 * lr, FULL - 2 * lr));

    // register extremes, one with the receiver holding off for a long stretch
    run_phase(14'd1, 15'd32767, 15'd0, 1'b0);
    run_phase(14'd16383, 15'd0, 15'd32767, 1'b1);
    run_phase(14'd0, 15'd1, 15'd32767, 1'b0);
    for (k = 0; k < 4; k++)
      run_phase(14'($urandom_range(1, 16383)), 15'($urandom_range(0, 32767)),
                15'($urandom_range(0, 32767)), 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
